// ----- design/aes_pkg.sv -----
// Shared types, S-box table and round helpers for the AES-128 encrypt core.
// No dependencies; used by every module in this folder.
package aes_pkg;

	localparam int unsigned NumRounds = 10;
	localparam int unsigned CfgIdxW   = 1;
	localparam int unsigned CfgDataW  = 64;

	localparam logic [CfgIdxW-1:0] RegKeyHigh = 1'b0;
	localparam logic [CfgIdxW-1:0] RegKeyLow  = 1'b1;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] cipher_high;
		logic [63:0] cipher_low;
	} out_beat_t;

	typedef logic [127:0] word128_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
		8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
		8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
		8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
		8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
		8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
		8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
		8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
		8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
		8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
		8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
		8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
		8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
		8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
		8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
		8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
		8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
		8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
		8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
		8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
		8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
		8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
		8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
		8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
		8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
		8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
		8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
		8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
		8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
		8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
		8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
		8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
	};

	localparam logic [7:0] RCON [NumRounds] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
	};

	function automatic logic [7:0] gf_double(input logic [7:0] v);
		return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of the FIPS state sits at bits [127-8i -: 8]
	function automatic logic [7:0] get_byte(input word128_t w, input int unsigned i);
		return w[127 - 8 * i -: 8];
	endfunction

	function automatic word128_t next_round_key(input word128_t k, input logic [7:0] rc);
		logic [7:0] kb [16];
		logic [7:0] t [4];
		word128_t   r;
		for (int i = 0; i < 16; i++) kb[i] = get_byte(k, i);
		t[0] = SBOX[kb[13]] ^ rc;
		t[1] = SBOX[kb[14]];
		t[2] = SBOX[kb[15]];
		t[3] = SBOX[kb[12]];
		for (int i = 0; i < 4; i++) kb[i] = kb[i] ^ t[i];
		for (int i = 4; i < 16; i++) kb[i] = kb[i] ^ kb[i - 4];
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = kb[i];
		return r;
	endfunction

	function automatic word128_t cipher_round(input word128_t s, input word128_t k,
			input logic last);
		logic [7:0] sb [16];
		logic [7:0] a0, a1, a2, a3, all;
		word128_t   r;
		for (int c = 0; c < 4; c++)
			for (int rw = 0; rw < 4; rw++)
				sb[c * 4 + rw] = SBOX[get_byte(s, ((c + rw) % 4) * 4 + rw)];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = sb[4 * c]; a1 = sb[4 * c + 1]; a2 = sb[4 * c + 2]; a3 = sb[4 * c + 3];
				all = a0 ^ a1 ^ a2 ^ a3;
				sb[4 * c]     = a0 ^ all ^ gf_double(a0 ^ a1);
				sb[4 * c + 1] = a1 ^ all ^ gf_double(a1 ^ a2);
				sb[4 * c + 2] = a2 ^ all ^ gf_double(a2 ^ a3);
				sb[4 * c + 3] = a3 ^ all ^ gf_double(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = sb[i];
		return r ^ k;
	endfunction

endpackage

// ----- design/aes_round_cell.sv -----
// One round cell: expands its round key and applies one cipher round.
// Depends on aes_pkg; instantiated in a row by the top level.
module aes_round_cell #(
	parameter logic [7:0] RC   = 8'h01,
	parameter bit         LAST = 1'b0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_in,
	input  aes_pkg::word128_t state_in,
	input  aes_pkg::word128_t key_in,
	output logic              valid_out,
	output aes_pkg::word128_t state_out,
	output aes_pkg::word128_t key_out
);

	aes_pkg::word128_t rkey;

	assign rkey = aes_pkg::next_round_key(key_in, RC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		state_out <= aes_pkg::cipher_round(state_in, rkey, LAST);
		key_out   <= rkey;
	end

endmodule

// ----- design/aes128_encrypt_block_core.sv -----
// Top level of the AES-128 encrypt core: key registers, input stage, round-cell row.
// Depends on aes_pkg and aes_round_cell.
//
//  channel  | ports                                | handshake
//  ---------+--------------------------------------+-------------------------
//  input    | start, busy, in_beat                 | beat taken: start & !busy
//  result   | done, out_beat                       | one-cycle strobe on done
//  config   | cfg_we, cfg_index, cfg_data          | write when cfg_we high
//
// One block enters per cycle; a taken block passes the input key-add stage and then
// ten round cells, each one register deep, before it is on the result ports.
// busy is held low: the row never stalls, and the receiver cannot stall it.
// Reset clears the key registers and the valid bits of every stage.
module aes128_encrypt_block_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  aes_pkg::in_beat_t                in_beat,
	output logic                             done,
	output aes_pkg::out_beat_t               out_beat,
	input  logic                             cfg_we,
	input  logic [aes_pkg::CfgIdxW-1:0]      cfg_index,
	input  logic [aes_pkg::CfgDataW-1:0]     cfg_data
);

	logic [63:0]       key_high_q;
	logic [63:0]       key_low_q;
	logic              valid_s0;
	aes_pkg::word128_t state_s0;
	aes_pkg::word128_t key_s0;

	logic              vld [aes_pkg::NumRounds+1];
	aes_pkg::word128_t st  [aes_pkg::NumRounds+1];
	aes_pkg::word128_t ky  [aes_pkg::NumRounds+1];

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			valid_s0   <= 1'b0;
		end else begin
			valid_s0 <= start && !busy;
			if (cfg_we) begin
				case (cfg_index)
					aes_pkg::RegKeyHigh: key_high_q <= cfg_data;
					aes_pkg::RegKeyLow:  key_low_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		state_s0 <= {in_beat.block_high, in_beat.block_low} ^ {key_high_q, key_low_q};
		key_s0   <= {key_high_q, key_low_q};
	end

	assign vld[0] = valid_s0;
	assign st[0]  = state_s0;
	assign ky[0]  = key_s0;

	for (genvar r = 0; r < aes_pkg::NumRounds; r++) begin : g_round
		aes_round_cell #(
			.RC   (aes_pkg::RCON[r]),
			.LAST (r == aes_pkg::NumRounds - 1)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.valid_in  (vld[r]),
			.state_in  (st[r]),
			.key_in    (ky[r]),
			.valid_out (vld[r+1]),
			.state_out (st[r+1]),
			.key_out   (ky[r+1])
		);
	end

	assign done                 = vld[aes_pkg::NumRounds];
	assign out_beat.cipher_high = st[aes_pkg::NumRounds][127:64];
	assign out_beat.cipher_low  = st[aes_pkg::NumRounds][63:0];

endmodule
